// ===== design/cotm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cotm_pkg
// Shared types and constants of the clock offset trimmed mean filter.
// ----------------------------------------------------------------------------
package cotm_pkg;

	localparam int GUARD_W     = 22;
	localparam int HOLDOFF_W   = 22;
	localparam int DEADBAND_W  = 20;
	localparam int SLEW_W      = 30;
	localparam int CFG_DATA_W  = 30;
	localparam int CFG_INDEX_W = 2;
	localparam int STEP_W      = 39;
	localparam int ACTION_W    = 2;
	localparam int DVS_W       = 10;

	localparam logic [GUARD_W-1:0]    GUARD_RESET    = GUARD_W'(1800);
	localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RESET  = HOLDOFF_W'(60000);
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(1000);
	localparam logic [SLEW_W-1:0]     SLEW_RESET     = SLEW_W'(1000000);
	localparam logic [DVS_W-1:0]      STEP_DIVISOR   = DVS_W'(1000);

	typedef enum logic {
		OP_SAMPLE,
		OP_TICK
	} op_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE,
		ACT_SLEW,
		ACT_STEP,
		ACT_TIMEOUT
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GUARD,
		CFG_HOLDOFF,
		CFG_DEADBAND,
		CFG_MAX_SLEW
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SUM,
		ST_MEAN_START,
		ST_MEAN_WAIT,
		ST_JUDGE,
		ST_STEP_START,
		ST_STEP_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic sum_step;
		logic div_start;
		logic div_step;
		logic judge;
		logic load_out;
	} cotm_cmd_t;

	typedef struct packed {
		logic eval_go;
		logic sum_last;
		logic div_busy;
		logic need_step;
		logic out_free;
	} cotm_status_t;

endpackage

// ===== design/cotm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cotm_div
// Unsigned divider by one of two constants, the mean divisor or the seconds
// divisor, working 12-bit chunks by reciprocal multiplication, a multiply
// step then a quotient-and-remainder step for each chunk.
// ----------------------------------------------------------------------------
module cotm_div
	import cotm_pkg::*;
#(
	parameter int DW   = 51,
	parameter int KEEP = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          step_mode,
	input  logic [DW-1:0] dividend,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CH      = 12;
	localparam int NCH     = (DW + CH - 1) / CH;
	localparam int PW      = NCH * CH;
	localparam int XW      = CH + DVS_W;
	localparam int MW      = XW + 1;
	localparam int PRW     = XW + MW;
	localparam int STEP_D  = int'(STEP_DIVISOR);
	localparam int SH_MEAN = XW + $clog2(KEEP);
	localparam int SH_STEP = XW + $clog2(STEP_D);
	localparam int CNT_W   = $clog2(NCH + 1);
	localparam longint MUL_MEAN =
		((longint'(1) << SH_MEAN) + longint'(KEEP - 1)) / longint'(KEEP);
	localparam longint MUL_STEP =
		((longint'(1) << SH_STEP) + longint'(STEP_D - 1)) / longint'(STEP_D);

	logic             busy_q;
	logic             phase_q;
	logic             mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    work_q;
	logic [DVS_W-1:0] rem_q;
	logic [PRW-1:0]   prod_q;
	logic [XW-1:0]    x;
	logic [MW-1:0]    mul;
	logic [DVS_W-1:0] dvs;
	logic [CH-1:0]    qc;
	logic [XW-1:0]    back;
	logic [XW-1:0]    r_full;

	// dividend chunks leave at the top of work_q, quotient chunks enter at the bottom
	always_comb begin
		x      = {rem_q, work_q[PW-1 -: CH]};
		mul    = mode_q ? MW'(MUL_STEP) : MW'(MUL_MEAN);
		dvs    = mode_q ? STEP_DIVISOR : DVS_W'(KEEP);
		qc     = mode_q ? prod_q[SH_STEP +: CH] : prod_q[SH_MEAN +: CH];
		back   = {{(XW-CH){1'b0}}, qc} * {{(XW-DVS_W){1'b0}}, dvs};
		r_full = x - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			cnt_q   <= CNT_W'(NCH);
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= PW'(dividend);
			rem_q  <= '0;
			mode_q <= step_mode;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= {{(PRW-XW){1'b0}}, x} * {{(PRW-MW){1'b0}}, mul};
			end else begin
				work_q <= {work_q[PW-CH-1:0], qc};
				rem_q  <= r_full[DVS_W-1:0];
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q[DW-1:0];

endmodule

// ===== design/cotm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cotm_ctrl
// Sequencer: accept, decide, sum kept entries, divide, judge, divide for a step, emit.
// ----------------------------------------------------------------------------
module cotm_ctrl
	import cotm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cotm_status_t status,
	output cotm_cmd_t    cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_n    = status.eval_go ? ST_SUM : ST_OUT;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (status.sum_last) begin
					state_n = ST_MEAN_START;
				end
			end
			ST_MEAN_START: begin
				cmd.div_start = 1'b1;
				state_n       = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!status.div_busy) begin
					state_n = ST_JUDGE;
				end
			end
			ST_JUDGE: begin
				cmd.judge = 1'b1;
				state_n   = status.need_step ? ST_STEP_START : ST_OUT;
			end
			ST_STEP_START: begin
				cmd.div_start = 1'b1;
				cmd.div_step  = 1'b1;
				state_n       = ST_STEP_WAIT;
			end
			ST_STEP_WAIT: begin
				if (!status.div_busy) begin
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/cotm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cotm_datapath
// Config registers, watchdog, insertion-sorted offset cells, accumulator,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module cotm_datapath
	import cotm_pkg::*;
#(
	parameter int SAMPLE_COUNT   = 10,
	parameter int TRIM_EACH_SIDE = 2,
	parameter int TIME_BITS      = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cotm_cmd_t              cmd,
	output cotm_status_t           status,
	input  logic                   in_op,
	input  logic [TIME_BITS-1:0]   in_ref,
	input  logic [TIME_BITS-1:0]   in_loc,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [ACTION_W-1:0]    out_action,
	output logic [TIME_BITS-1:0]   out_offset,
	output logic [STEP_W-1:0]      out_step
);

	localparam int N        = SAMPLE_COUNT;
	localparam int T        = TIME_BITS;
	localparam int TRIM_EFF = (2 * TRIM_EACH_SIDE < N) ? TRIM_EACH_SIDE : (N - 1) / 2;
	localparam int KEEP     = N - 2 * TRIM_EFF;
	localparam int KEEP_LOG = $clog2(KEEP);
	localparam int IDX_W    = $clog2(N);
	localparam int OFF_W    = T + 1;
	localparam int ACC_W    = T + KEEP_LOG + 1;
	localparam int DW       = ACC_W - 1;

	// configuration
	logic [GUARD_W-1:0]    guard_q;
	logic [HOLDOFF_W-1:0]  holdoff_q;
	logic [DEADBAND_W-1:0] deadband_q;
	logic [SLEW_W-1:0]     slew_q;

	// item and state
	op_t                     op_q;
	logic [T-1:0]            ref_q;
	logic signed [OFF_W-1:0] off_q;
	logic signed [OFF_W-1:0] s_q [N];
	logic signed [OFF_W-1:0] s_next [N];
	logic [N-1:0]            lt;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        k_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [T-1:0]            last_q;
	logic [GUARD_W-1:0]      wd_q;
	logic                    rep_q;
	action_t                 res_action_q;
	logic [T-1:0]            res_offset_q;

	// output register
	logic                out_valid_q;
	logic [ACTION_W-1:0] out_action_q;
	logic [T-1:0]        out_offset_q;
	logic [STEP_W-1:0]   out_step_q;

	// combinational
	logic                is_tick;
	logic                ref_zero;
	logic                held;
	logic                sample_ok;
	logic                eval_due;
	logic [T-1:0]        hold_diff;
	logic [GUARD_W-1:0]  wd_dec;
	logic                fires;
	logic [ACC_W-1:0]    acc_neg;
	logic [DW-1:0]       acc_abs;
	logic [DW-1:0]       div_dividend;
	logic                div_busy;
	logic [DW-1:0]       quo;
	logic [T-1:0]        mag;
	logic                beyond_band;
	logic                need_step;
	logic                avg_neg;
	logic [T-1:0]        avg_sat;
	logic [T-1:0]        off_sat;
	logic [STEP_W+DW-1:0] quo_ext;

	always_comb begin
		is_tick   = op_q == OP_TICK;
		ref_zero  = ref_q == '0;
		hold_diff = ref_q - last_q;
		held      = hold_diff < T'(holdoff_q);
		sample_ok = !is_tick && !ref_zero && !held;
		eval_due  = idx_q == IDX_W'(N - 1);
		wd_dec    = (wd_q != '0) ? wd_q - 1'b1 : wd_q;
		fires     = (guard_q != '0) && (wd_dec == '0) && !rep_q;
	end

	// insertion cells: the prefix below the new offset holds, the rest shifts up
	for (genvar k = 0; k < N; k++) begin : g_cell
		assign lt[k] = (IDX_W'(k) < idx_q) && (s_q[k] <= off_q);
		if (k == 0) begin : g_first
			assign s_next[k] = lt[k] ? s_q[k] : off_q;
		end else begin : g_rest
			assign s_next[k] = lt[k] ? s_q[k] : (lt[k-1] ? off_q : s_q[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && sample_ok) begin
			s_q <= s_next;
		end
	end

	// mean magnitude, sign and saturation
	always_comb begin
		acc_neg = -acc_q;
		avg_neg = acc_q[ACC_W-1];
		acc_abs = avg_neg ? acc_neg[DW-1:0] : acc_q[DW-1:0];
		mag     = quo[T-1:0];
		beyond_band = mag >= T'(deadband_q);
		need_step   = beyond_band && (mag >= T'(slew_q));
		if (!avg_neg) begin
			avg_sat = mag[T-1] ? {1'b0, {(T-1){1'b1}}} : mag;
		end else if (mag[T-1] && (|mag[T-2:0])) begin
			avg_sat = {1'b1, {(T-1){1'b0}}};
		end else begin
			avg_sat = -mag;
		end
		if (!off_q[T] && off_q[T-1]) begin
			off_sat = {1'b0, {(T-1){1'b1}}};
		end else if (off_q[T] && !off_q[T-1]) begin
			off_sat = {1'b1, {(T-1){1'b0}}};
		end else begin
			off_sat = off_q[T-1:0];
		end
		div_dividend = cmd.div_step ? DW'(ref_q) : acc_abs;
		quo_ext      = {{STEP_W{1'b0}}, quo};
	end

	cotm_div #(
		.DW  (DW),
		.KEEP(KEEP)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.step_mode(cmd.div_step),
		.dividend (div_dividend),
		.busy     (div_busy),
		.quotient (quo)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(in_op);
			ref_q <= in_ref;
			off_q <= $signed({1'b0, in_ref}) - $signed({1'b0, in_loc});
		end
		if (cmd.decide) begin
			res_action_q <= (is_tick && fires) ? ACT_TIMEOUT : ACT_NONE;
			res_offset_q <= '0;
			acc_q        <= '0;
			k_q          <= IDX_W'(TRIM_EFF);
		end
		if (cmd.sum_step) begin
			acc_q <= acc_q + ACC_W'(s_q[k_q]);
			k_q   <= k_q + 1'b1;
		end
		if (cmd.judge && beyond_band) begin
			res_action_q <= need_step ? ACT_STEP : ACT_SLEW;
			res_offset_q <= need_step ? off_sat : avg_sat;
		end
		if (cmd.load_out) begin
			out_action_q <= res_action_q;
			out_offset_q <= res_offset_q;
			out_step_q   <= (res_action_q == ACT_STEP) ? quo_ext[STEP_W-1:0] : '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q     <= GUARD_RESET;
			holdoff_q   <= HOLDOFF_RESET;
			deadband_q  <= DEADBAND_RESET;
			slew_q      <= SLEW_RESET;
			idx_q       <= '0;
			last_q      <= '0;
			wd_q        <= GUARD_RESET;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GUARD:    guard_q    <= cfg_data[GUARD_W-1:0];
					CFG_HOLDOFF:  holdoff_q  <= cfg_data[HOLDOFF_W-1:0];
					CFG_DEADBAND: deadband_q <= cfg_data[DEADBAND_W-1:0];
					CFG_MAX_SLEW: slew_q     <= cfg_data[SLEW_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.decide) begin
				if (is_tick) begin
					if (guard_q != '0) begin
						wd_q <= wd_dec;
						if (fires) begin
							rep_q <= 1'b1;
						end
					end
				end else if (!ref_zero) begin
					wd_q  <= guard_q;
					rep_q <= 1'b0;
					if (!held) begin
						idx_q <= eval_due ? '0 : idx_q + 1'b1;
					end
				end
			end
			if (cmd.judge && beyond_band) begin
				last_q <= ref_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.eval_go   = sample_ok && eval_due;
		status.sum_last  = k_q == IDX_W'(TRIM_EFF + KEEP - 1);
		status.div_busy  = div_busy;
		status.need_step = need_step;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_action = out_action_q;
	assign out_offset = out_offset_q;
	assign out_step   = out_step_q;

endmodule

// ===== design/clock_offset_trimmed_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_trimmed_mean
// Clock offset filter: trimmed mean of the last offsets plus a reference
// watchdog, emitting one action per transfer.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a timestamp sample or a one-second tick, tdata
// carries the reference and local times. Every input transfer yields exactly
// one output transfer: action in tuser, offset and step seconds in tdata.
// Configuration writes go through the cfg channel, which is always ready;
// write it only while no item is in work.
// One item is worked at a time. An item that does not close a round of
// samples passes through accept, decide and the load of the output
// register. The sample that closes a round adds the kept-entry sum and
// the mean division; a step adds the seconds division. The divider takes
// 12-bit chunks, NCH = ceil(DW / 12) with DW = TIME_BITS + clog2(KEEP):
// 5 chunks by default with KEEP = 6.
// The output register lets a finished result wait while the next item is
// accepted; a stalled receiver stops the block only when a second result
// is ready. Reset clears the round, the hold-off time and the timeout flag,
// loads the watchdog and the registers with their defaults, and empties
// the output register.
// ----------------------------------------------------------------------------
module clock_offset_trimmed_mean
	import cotm_pkg::*;
#(
	parameter int SAMPLE_COUNT   = 10,
	parameter int TRIM_EACH_SIDE = 2,
	parameter int TIME_BITS      = 48,
	localparam int IN_DATA_W     = ((2 * TIME_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W    = ((TIME_BITS + STEP_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // ref_time_ms, local_time_ms
	input  logic                   s_axis_tuser,   // op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // offset_ms, step_seconds
	output logic [ACTION_W-1:0]    m_axis_tuser,   // action
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cotm_cmd_t              cmd;
	cotm_status_t           status;
	logic [TIME_BITS-1:0]   out_offset;
	logic [STEP_W-1:0]      out_step;

	assign cfg_ready = 1'b1;

	cotm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	cotm_datapath #(
		.SAMPLE_COUNT  (SAMPLE_COUNT),
		.TRIM_EACH_SIDE(TRIM_EACH_SIDE),
		.TIME_BITS     (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (s_axis_tuser),
		.in_ref    (s_axis_tdata[TIME_BITS-1:0]),
		.in_loc    (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_action(m_axis_tuser),
		.out_offset(out_offset),
		.out_step  (out_step)
	);

	assign m_axis_tdata = OUT_DATA_W'({out_step, out_offset});

endmodule

// ===== design/cotm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cotm_checker
// Port-level checks of the clock offset filter, bound to the top level.
// ----------------------------------------------------------------------------
module cotm_checker
	import cotm_pkg::*;
#(
	parameter int TIME_BITS = 48,
	localparam int OUT_DATA_W = ((TIME_BITS + STEP_W + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [ACTION_W-1:0]   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while one is in work");

	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ACT_NONE || m_axis_tuser == ACT_TIMEOUT)
		|-> m_axis_tdata == '0)
		else $error("nonzero payload on an idle or timeout action");

	a_slew_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ACT_SLEW |-> m_axis_tdata[TIME_BITS +: STEP_W] == '0)
		else $error("step seconds set on a slew action");

endmodule

bind clock_offset_trimmed_mean cotm_checker #(
	.TIME_BITS(TIME_BITS)
) u_cotm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ===== dv/clock_offset_trimmed_mean_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_offset_trimmed_mean_tb
// Self-checking bench for the clock offset trimmed mean filter. Directed
// tests hit field extremes, the watchdog and a trimmed round; random rounds
// of well-formed samples mixed with ticks, invalid and held-off samples run
// under several register settings and idle patterns, plus a long output
// stall. A local model of the filter predicts every result in order.
// ----------------------------------------------------------------------------
module clock_offset_trimmed_mean_tb;
	import cotm_pkg::*;

	localparam int SAMPLES     = 10;
	localparam int TRIM        = 2;
	localparam int TIME_BITS   = 48;
	localparam int TRIM_EFF    = (2 * TRIM < SAMPLES) ? TRIM : (SAMPLES - 1) / 2;
	localparam int KEEP        = SAMPLES - 2 * TRIM_EFF;
	localparam int IN_W        = ((2 * TIME_BITS + 7) / 8) * 8;
	localparam int OUT_W       = ((TIME_BITS + STEP_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 150;
	localparam longint OFF_MAX = (longint'(1) << (TIME_BITS - 1)) - 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct {
		action_t                action;
		logic [TIME_BITS-1:0]   offset;
		logic [STEP_W-1:0]      step;
	} offset_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_W-1:0]        s_axis_tdata = '0;   // ref_time_ms, local_time_ms
	logic                   s_axis_tuser = 1'b0; // op
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_W-1:0]       m_axis_tdata;        // offset_ms, step_seconds
	logic [ACTION_W-1:0]    m_axis_tuser;        // action
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	offset_result_t expected_actions[$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	logic [TIME_BITS-1:0] now_ms = 48'h0100_0000_0000;

	logic [GUARD_W-1:0]    guard_cfg = GUARD_RESET;
	logic [HOLDOFF_W-1:0]  holdoff_cfg = HOLDOFF_RESET;
	logic [DEADBAND_W-1:0] deadband_cfg = DEADBAND_RESET;
	logic [SLEW_W-1:0]     slew_cfg = SLEW_RESET;
	longint                offset_ring [SAMPLES];
	int                    round_fill = 0;
	logic [TIME_BITS-1:0]  last_adjust_ms = '0;
	logic [GUARD_W-1:0]    watchdog_left = GUARD_RESET;
	logic                  timeout_sent = 1'b0;

	clock_offset_trimmed_mean #(
		.SAMPLE_COUNT(SAMPLES),
		.TRIM_EACH_SIDE(TRIM),
		.TIME_BITS(TIME_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [TIME_BITS-1:0] rand_time();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [TIME_BITS-1:0] saturate_offset(input longint v);
		if (v > OFF_MAX)
			return TIME_BITS'(OFF_MAX);
		if (v < -OFF_MAX - 1)
			return TIME_BITS'(-OFF_MAX - 1);
		return TIME_BITS'(v);
	endfunction

	function automatic offset_result_t filter_predict(input op_t op,
		input logic [TIME_BITS-1:0] ref_ms, input logic [TIME_BITS-1:0] loc_ms);
		offset_result_t res;
		longint sorted_offs [SAMPLES];
		longint off, v, sum, avg, mag;
		logic [TIME_BITS-1:0] since_adjust;
		int j;
		res.action = ACT_NONE;
		res.offset = '0;
		res.step = '0;
		if (op == OP_TICK) begin
			if (guard_cfg != '0) begin
				if (watchdog_left != '0)
					watchdog_left = watchdog_left - 1'b1;
				if (watchdog_left == '0 && !timeout_sent) begin
					timeout_sent = 1'b1;
					res.action = ACT_TIMEOUT;
				end
			end
			return res;
		end
		if (ref_ms == '0)
			return res;
		watchdog_left = guard_cfg;
		timeout_sent = 1'b0;
		since_adjust = ref_ms - last_adjust_ms;
		if (since_adjust < TIME_BITS'(holdoff_cfg))
			return res;
		off = (ref_ms >= loc_ms) ? longint'({{(64 - TIME_BITS){1'b0}}, ref_ms - loc_ms})
			: -longint'({{(64 - TIME_BITS){1'b0}}, loc_ms - ref_ms});
		round_fill = (round_fill + 1) % SAMPLES;
		offset_ring[round_fill] = off;
		if (round_fill != 0)
			return res;
		sorted_offs = offset_ring;
		for (int i = 1; i < SAMPLES; i++) begin
			v = sorted_offs[i];
			j = i;
			while (j > 0 && sorted_offs[j-1] > v) begin
				sorted_offs[j] = sorted_offs[j-1];
				j--;
			end
			sorted_offs[j] = v;
		end
		sum = 0;
		for (int i = TRIM_EFF; i < TRIM_EFF + KEEP; i++)
			sum += sorted_offs[i];
		avg = sum / KEEP;
		mag = (avg < 0) ? -avg : avg;
		if (mag < longint'(deadband_cfg))
			return res;
		last_adjust_ms = ref_ms;
		if (mag < longint'(slew_cfg)) begin
			res.action = ACT_SLEW;
			res.offset = saturate_offset(avg);
		end else begin
			res.action = ACT_STEP;
			res.offset = saturate_offset(off);
			res.step = STEP_W'(ref_ms / STEP_DIVISOR);
		end
		return res;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL clock_offset_trimmed_mean");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold = recv_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		offset_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_actions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: action %0d offset %h step %h",
						m_axis_tuser, m_axis_tdata[TIME_BITS-1:0],
						m_axis_tdata[TIME_BITS+STEP_W-1:TIME_BITS]);
			end else begin
				want = expected_actions.pop_front();
				if (m_axis_tuser !== want.action
						|| m_axis_tdata[TIME_BITS-1:0] !== want.offset
						|| m_axis_tdata[TIME_BITS+STEP_W-1:TIME_BITS] !== want.step) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected action %0d offset %h step %h, got %0d %h %h",
							want.action, want.offset, want.step, m_axis_tuser,
							m_axis_tdata[TIME_BITS-1:0],
							m_axis_tdata[TIME_BITS+STEP_W-1:TIME_BITS]);
				end
			end
		end
	end

	task automatic send_item(input op_t op, input logic [TIME_BITS-1:0] ref_ms,
		input logic [TIME_BITS-1:0] loc_ms);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= IN_W'({loc_ms, ref_ms});
		do @(posedge clk); while (!s_axis_tready);
		expected_actions.push_back(filter_predict(op, ref_ms, loc_ms));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GUARD:    guard_cfg = value[GUARD_W-1:0];
			CFG_HOLDOFF:  holdoff_cfg = value[HOLDOFF_W-1:0];
			CFG_DEADBAND: deadband_cfg = value[DEADBAND_W-1:0];
			CFG_MAX_SLEW: slew_cfg = value[SLEW_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input int unsigned guard, input int unsigned holdoff,
		input int unsigned deadband, input int unsigned slew);
		write_reg(CFG_GUARD, CFG_DATA_W'(guard));
		write_reg(CFG_HOLDOFF, CFG_DATA_W'(holdoff));
		write_reg(CFG_DEADBAND, CFG_DATA_W'(deadband));
		write_reg(CFG_MAX_SLEW, CFG_DATA_W'(slew));
		cfg_valid <= 1'b0;
	endtask

	// Rounds of ten samples around a chosen offset or at field extremes, with noise between samples.
	task automatic run_rounds(input int target);
		int sent, mode, spread, bursts;
		bit outliers;
		longint center, off;
		logic [TIME_BITS-1:0] ref_ms;
		sent = 0;
		while (sent < target) begin
			mode = $urandom_range(4);
			case (mode)
				0: center = (deadband_cfg == 0) ? 0 : longint'($urandom_range(deadband_cfg - 1));
				1: center = (slew_cfg > deadband_cfg)
					? longint'($urandom_range(slew_cfg - 1, deadband_cfg)) : longint'(deadband_cfg);
				2: center = longint'(slew_cfg) + ($urandom_range(1)
					? longint'($urandom_range(1 << 20)) : longint'($urandom) << 8);
				default:
					case ($urandom_range(3))
						0: center = (deadband_cfg == 0) ? 0 : longint'(deadband_cfg) - 1;
						1: center = longint'(deadband_cfg);
						2: center = (slew_cfg == 0) ? 0 : longint'(slew_cfg) - 1;
						default: center = longint'(slew_cfg);
					endcase
			endcase
			if ($urandom_range(1))
				center = -center;
			spread = (mode == 3) ? 0 : $urandom_range(20);
			outliers = (mode != 3) && $urandom_range(1);
			now_ms = now_ms + holdoff_cfg + $urandom_range(2000);
			for (int k = 0; k < SAMPLES; k++) begin
				if ($urandom_range(99) < 15) begin
					case ($urandom_range(3))
						0: begin
							bursts = $urandom_range(6, 1);
							repeat (bursts)
								send_item(OP_TICK, rand_time(), rand_time());
							sent += bursts;
						end
						1: send_item(OP_SAMPLE, '0, rand_time());
						2: begin
							send_item(OP_SAMPLE, last_adjust_ms
								+ ((holdoff_cfg == 0) ? 0 : $urandom_range(holdoff_cfg - 1)),
								rand_time());
							sent++;
						end
						default: begin
							send_item(OP_SAMPLE, rand_time(), rand_time());
							sent++;
						end
					endcase
				end
				if (mode == 4) begin
					if (center >= 0)
						send_item(OP_SAMPLE, rand_time() | (48'h1 << 47), rand_time() >> 8);
					else
						send_item(OP_SAMPLE, (rand_time() >> 8) | 48'h1,
							rand_time() | (48'h1 << 47));
				end else begin
					now_ms = now_ms + $urandom_range(1000, 1);
					off = center + longint'($urandom_range(2 * spread)) - spread;
					if (outliers && k < 4)
						off = (k % 2 == 1) ? (longint'($urandom) << 8) : -(longint'($urandom) << 8);
					ref_ms = now_ms;
					send_item(OP_SAMPLE, ref_ms, ref_ms - TIME_BITS'(off));
				end
				sent++;
			end
		end
	endtask

	task automatic test_field_extremes();
		send_item(OP_TICK, TIME_MAX, TIME_MAX);
		send_item(OP_SAMPLE, '0, TIME_MAX);
		send_item(OP_SAMPLE, TIME_MAX, '0);
		send_item(OP_SAMPLE, TIME_MAX, TIME_MAX);
		send_item(OP_SAMPLE, 48'd1, TIME_MAX);
		send_item(OP_SAMPLE, 48'd60000, '0);
		send_item(OP_SAMPLE, 48'd59999, 48'd1);
		send_item(OP_TICK, '0, '0);
		wait_idle();
	endtask

	task automatic test_watchdog();
		set_config(2, HOLDOFF_RESET, DEADBAND_RESET, SLEW_RESET);
		send_item(OP_TICK, '0, '0);
		send_item(OP_SAMPLE, now_ms, now_ms);
		repeat (3)
			send_item(OP_TICK, '0, '0);
		send_item(OP_SAMPLE, '0, now_ms);
		send_item(OP_TICK, '0, '0);
		send_item(OP_SAMPLE, now_ms, now_ms);
		repeat (2)
			send_item(OP_TICK, '0, '0);
		wait_idle();
		set_config(0, HOLDOFF_RESET, DEADBAND_RESET, SLEW_RESET);
		repeat (2)
			send_item(OP_TICK, '0, '0);
		wait_idle();
	endtask

	task automatic test_trimmed_round();
		set_config(GUARD_RESET, 0, DEADBAND_RESET, SLEW_RESET);
		while (round_fill != 0)
			send_item(OP_SAMPLE, now_ms, now_ms);
		send_item(OP_SAMPLE, TIME_MAX, '0);
		send_item(OP_SAMPLE, 48'd1, TIME_MAX);
		send_item(OP_SAMPLE, 48'h8000_0000_0000, '0);
		send_item(OP_SAMPLE, 48'd1, 48'h8000_0000_0001);
		for (int k = 0; k < KEEP; k++)
			send_item(OP_SAMPLE, now_ms + k, now_ms - 5000);
		wait_idle();
	endtask

	task automatic test_output_stall();
		set_config(GUARD_RESET, HOLDOFF_RESET, DEADBAND_RESET, SLEW_RESET);
		send_idle_pct = 0;
		recv_idle_pct = 13;
		recv_hold = 3000;
		run_rounds(40);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input int unsigned guard, input int unsigned holdoff,
		input int unsigned deadband, input int unsigned slew);
		wait_idle();
		set_config(guard, holdoff, deadband, slew);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		run_rounds(290);
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 13;
		recv_idle_pct = 87;
		test_field_extremes();
		test_watchdog();
		test_trimmed_round();
		test_output_stall();
		test_random_traffic(13, 87, 3, 0, 0, 1);
		test_random_traffic(13, 87, 1800, 60000, 1000, 1000000);
		test_random_traffic(87, 13, 0, 3600000, 1000000, 1000000000);
		test_random_traffic(87, 13, 3932100, 1, 1, 2);
		test_random_traffic(0, 0, 2, 500, 250, 5000);
		test_random_traffic(0, 0, 5, 30000, 77, 0);
		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_actions.size() != 0)
			$display("missing results: %0d", expected_actions.size());
		if (mismatches == 0 && expected_actions.size() == 0) begin
			$display("PASS clock_offset_trimmed_mean");
		end else begin
			$display("FAIL clock_offset_trimmed_mean");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/cotm_pkg.sv
design/cotm_div.sv
design/cotm_ctrl.sv
design/cotm_datapath.sv
design/clock_offset_trimmed_mean.sv
design/cotm_checker.sv
dv/clock_offset_trimmed_mean_tb.sv
